// ===== design/kcl_pkg.sv =====
// ----------------------------------------------------------------------------
// kcl_pkg
// Shared types and constants for the keypad code lock.
// ----------------------------------------------------------------------------
package kcl_pkg;

   localparam int KEY_W     = 4;
   localparam int PRESET_W  = 16;
   localparam int SLOT_W    = 2;
   localparam int KEYS_W    = 3;

   localparam int CODE_KEYS_DEF  = 4;
   localparam int USER_SLOTS_DEF = 3;

   localparam logic [KEY_W-1:0]    KEY_STAR     = 4'd10;
   localparam logic [KEY_W-1:0]    KEY_HASH     = 4'd11;
   localparam logic [PRESET_W-1:0] PRESET_RESET = 16'h1337;

   typedef enum logic [2:0] {
      ST_TAKEN       = 3'd0,
      ST_GOOD        = 3'd1,
      ST_BAD         = 3'd2,
      ST_SETMODE     = 3'd3,
      ST_STORED      = 3'd4,
      ST_STORED_LAST = 3'd5,
      ST_FULL        = 3'd6,
      ST_NOT_VALID   = 3'd7
   } status_type;

   typedef struct packed {
      status_type        status;
      logic [SLOT_W-1:0] slot_stored;
      logic [KEYS_W-1:0] keys_entered;
   } result_type;

endpackage

// ===== design/kcl_key_reg.sv =====
// ----------------------------------------------------------------------------
// kcl_key_reg
// Input register: holds one key code until the engine stage advances.
// ----------------------------------------------------------------------------
module kcl_key_reg
   import kcl_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [KEY_W-1:0] req_key_code,
   output logic             key_valid,
   input  logic             key_take,
   output logic [KEY_W-1:0] key_code
);

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff;

   assign req_ready = !valid_ff || key_take;
   assign valid_in  = req_valid || (valid_ff && !key_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         key_ff <= req_key_code;
      end
   end

   assign key_valid = valid_ff;
   assign key_code  = key_ff;

endmodule

// ===== design/kcl_engine.sv =====
// ----------------------------------------------------------------------------
// kcl_engine
// Lock state, preset register and the single-pass key decode.
// ----------------------------------------------------------------------------
module kcl_engine
   import kcl_pkg::*;
#(
   parameter int CODE_KEYS  = CODE_KEYS_DEF,
   parameter int USER_SLOTS = USER_SLOTS_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [PRESET_W-1:0] csr_wdata,
   input  logic                fire,
   input  logic [KEY_W-1:0]    key,
   output result_type          result
);

   localparam int CODE_W  = KEY_W * CODE_KEYS;
   localparam int CMP_W   = (CODE_W > PRESET_W) ? CODE_W : PRESET_W;
   localparam int CNT_W   = $clog2(CODE_KEYS + 1);
   localparam int IDX_W   = (CODE_KEYS > 1) ? $clog2(CODE_KEYS) : 1;
   localparam int SIDX_W  = (USER_SLOTS > 1) ? $clog2(USER_SLOTS) : 1;

   logic [PRESET_W-1:0]   preset_ff;
   logic                  set_mode_ff, set_mode_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  last_star_ff, last_star_in;
   logic [KEY_W-1:0]      entry_keys_ff [CODE_KEYS];
   logic [CODE_W-1:0]     user_codes_ff [USER_SLOTS];
   logic [USER_SLOTS-1:0] slot_filled_ff, slot_filled_in;

   logic [IDX_W-1:0]      cnt_idx;
   logic [KEY_W-1:0]      keys_next [CODE_KEYS];
   logic [CODE_W-1:0]     code_next;
   logic                  bad_key, trigger, complete;
   logic                  good, digits_only, found;
   logic [SIDX_W-1:0]     free_idx;
   logic [USER_SLOTS-1:0] free_onehot;
   logic                  entry_we, store_we;
   logic [CNT_W+KEYS_W-1:0]  keys_wide;
   logic [SIDX_W+SLOT_W-1:0] slot_wide;

   assign cnt_idx = cnt_ff[IDX_W-1:0];

   always_comb begin
      for (int i = 0; i < CODE_KEYS; i++) begin
         keys_next[i] = (cnt_idx == IDX_W'(i)) ? key : entry_keys_ff[i];
         code_next[(CODE_KEYS-1-i)*KEY_W +: KEY_W] = keys_next[i];
      end
   end

   always_comb begin
      good = (CMP_W'(code_next) == CMP_W'(preset_ff));
      for (int i = 0; i < USER_SLOTS; i++) begin
         if (slot_filled_ff[i] && user_codes_ff[i] == code_next) begin
            good = 1'b1;
         end
      end
      digits_only = 1'b1;
      for (int i = 0; i < CODE_KEYS; i++) begin
         if (keys_next[i] == KEY_STAR || keys_next[i] == KEY_HASH) begin
            digits_only = 1'b0;
         end
      end
      // lowest empty slot wins
      found       = 1'b0;
      free_idx    = '0;
      free_onehot = '0;
      for (int i = USER_SLOTS - 1; i >= 0; i--) begin
         if (!slot_filled_ff[i]) begin
            found       = 1'b1;
            free_idx    = SIDX_W'(i);
            free_onehot = USER_SLOTS'(1) << i;
         end
      end
   end

   assign bad_key  = (key > KEY_HASH) || (cnt_ff >= CNT_W'(CODE_KEYS));
   assign trigger  = !set_mode_ff && key == KEY_STAR && cnt_ff != '0 &&
                     last_star_ff && entry_keys_ff[0] == KEY_STAR;
   assign complete = (cnt_ff == CNT_W'(CODE_KEYS - 1));

   always_comb begin
      set_mode_in    = set_mode_ff;
      cnt_in         = cnt_ff;
      last_star_in   = last_star_ff;
      slot_filled_in = slot_filled_ff;
      entry_we       = 1'b0;
      store_we       = 1'b0;
      result.status  = ST_NOT_VALID;
      keys_wide      = {{KEYS_W{1'b0}}, cnt_ff};
      slot_wide      = '0;
      if (bad_key) begin
         result.status = ST_NOT_VALID;
      end else if (trigger) begin
         set_mode_in   = 1'b1;
         cnt_in        = '0;
         keys_wide     = '0;
         result.status = ST_SETMODE;
      end else begin
         entry_we     = 1'b1;
         last_star_in = (key == KEY_STAR);
         if (!complete) begin
            cnt_in        = CNT_W'(cnt_ff + 1'b1);
            keys_wide     = {{KEYS_W{1'b0}}, CNT_W'(cnt_ff + 1'b1)};
            result.status = ST_TAKEN;
         end else begin
            cnt_in    = '0;
            keys_wide = '0;
            if (!set_mode_ff) begin
               result.status = good ? ST_GOOD : ST_BAD;
            end else begin
               set_mode_in = 1'b0;
               if (!digits_only) begin
                  result.status = ST_NOT_VALID;
               end else if (found) begin
                  store_we       = 1'b1;
                  slot_filled_in = slot_filled_ff | free_onehot;
                  slot_wide      = {{SLOT_W{1'b0}}, free_idx};
                  result.status  = (&slot_filled_in) ? ST_STORED_LAST : ST_STORED;
               end else begin
                  result.status = ST_FULL;
               end
            end
         end
      end
      result.keys_entered = keys_wide[KEYS_W-1:0];
      result.slot_stored  = slot_wide[SLOT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         preset_ff      <= PRESET_RESET;
         set_mode_ff    <= 1'b0;
         cnt_ff         <= '0;
         last_star_ff   <= 1'b0;
         slot_filled_ff <= '0;
      end else begin
         if (csr_write) begin
            preset_ff <= csr_wdata;
         end
         if (fire) begin
            set_mode_ff    <= set_mode_in;
            cnt_ff         <= cnt_in;
            last_star_ff   <= last_star_in;
            slot_filled_ff <= slot_filled_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && entry_we) begin
         entry_keys_ff[cnt_idx] <= key;
      end
      if (fire && store_we) begin
         user_codes_ff[free_idx] <= code_next;
      end
   end

`ifndef SYNTHESIS
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff < CNT_W'(CODE_KEYS))
      else $error("key count out of range");

   a_setmode_enter: assert property (@(posedge clock) disable iff (reset)
      fire && result.status == ST_SETMODE |=> set_mode_ff && cnt_ff == '0)
      else $error("set mode not entered");

   a_store_fills: assert property (@(posedge clock) disable iff (reset)
      fire && (result.status == ST_STORED || result.status == ST_STORED_LAST)
      |=> $countones(slot_filled_ff) == $countones($past(slot_filled_ff)) + 1)
      else $error("store did not fill exactly one slot");

   a_filled_sticky: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (slot_filled_ff & $past(slot_filled_ff)) == $past(slot_filled_ff))
      else $error("user slot emptied");
`endif

endmodule

// ===== design/kcl_rsp_reg.sv =====
// ----------------------------------------------------------------------------
// kcl_rsp_reg
// Result register: holds one result until the receiver takes it.
// ----------------------------------------------------------------------------
module kcl_rsp_reg
   import kcl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  result_type        in_result,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_status,
   output logic [SLOT_W-1:0] rsp_slot_stored,
   output logic [KEYS_W-1:0] rsp_keys_entered
);

   logic       valid_ff;
   result_type result_ff;

   assign in_ready = !valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         result_ff <= in_result;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_status       = result_ff.status;
   assign rsp_slot_stored  = result_ff.slot_stored;
   assign rsp_keys_entered = result_ff.keys_entered;

endmodule

// ===== design/keypad_code_lock.sv =====
// ----------------------------------------------------------------------------
// keypad_code_lock
// Keypad code lock: gathers key codes into codes, checks or stores them.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one key code per transaction (0-9 digit, 10 star, 11 hash).
//   rsp_*  : exactly one result per key: status, slot_stored, keys_entered.
//   csr_*  : write of the preset code; csr_ready is always high. Write only
//            while no key transaction is in flight.
// Path: the accept edge loads the input register; the result register then
//   loads through the decode and raises rsp_valid.
// Throughput: one key per cycle while the result register is not stalled; the lock
//   state updates as the key moves from the input register into the result register.
// Stall: when rsp_ready is low the result register holds; the input
//   register still takes one more key, after which req_ready drops until
//   the result is taken.
// Reset: entry mode, empty partial code, all user slots empty, preset code
//   back to 0x1337. User codes and key storage are not cleared.
// ----------------------------------------------------------------------------
module keypad_code_lock
   import kcl_pkg::*;
#(
   parameter int CODE_KEYS  = CODE_KEYS_DEF,
   parameter int USER_SLOTS = USER_SLOTS_DEF
)
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [KEY_W-1:0]    req_key_code,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [2:0]          rsp_status,
   output logic [SLOT_W-1:0]   rsp_slot_stored,
   output logic [KEYS_W-1:0]   rsp_keys_entered,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [PRESET_W-1:0] csr_wdata
);

   logic             key_valid;
   logic             key_take;
   logic [KEY_W-1:0] key_code;
   result_type       result;

   assign csr_ready = 1'b1;

   kcl_key_reg u_key_reg (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_key_code (req_key_code),
      .key_valid    (key_valid),
      .key_take     (key_take),
      .key_code     (key_code)
   );

   kcl_engine #(
      .CODE_KEYS  (CODE_KEYS),
      .USER_SLOTS (USER_SLOTS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_valid && csr_ready),
      .csr_wdata (csr_wdata),
      .fire      (key_valid && key_take),
      .key       (key_code),
      .result    (result)
   );

   kcl_rsp_reg u_rsp_reg (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (key_valid),
      .in_ready         (key_take),
      .in_result        (result),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_slot_stored  (rsp_slot_stored),
      .rsp_keys_entered (rsp_keys_entered)
   );

endmodule
